// ===== src/sst_pkg.sv =====
package sst_pkg;

  // Limits
  localparam int MAX_DEPTH = 64;
  localparam int MAX_NODES = 65536;
  localparam int MAX_CHARS = 16777216;

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W  = $clog2(MAX_DEPTH);
  localparam int NODES_W = $clog2(MAX_NODES + 1);
  localparam int POS_W   = $clog2(MAX_CHARS + 1);

  // Field widths fixed by the result format
  localparam int CHAR_W  = 21;
  localparam int KIND_W  = 3;
  localparam int NODE_W  = 16;
  localparam int PAR_W   = 17;
  localparam int START_W = 24;
  localparam int END_W   = 25;
  localparam int CNT_W   = 17;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Event kinds
  localparam logic [KIND_W-1:0] EV_OPEN      = 3'd0;
  localparam logic [KIND_W-1:0] EV_CLOSE     = 3'd1;
  localparam logic [KIND_W-1:0] EV_ATOM_CHAR = 3'd2;
  localparam logic [KIND_W-1:0] EV_ATOM_END  = 3'd3;
  localparam logic [KIND_W-1:0] EV_FINISH    = 3'd4;

  localparam logic signed [PAR_W-1:0] PARENT_ROOT = -17'sd1;

  // Characters
  localparam logic [CHAR_W-1:0] CH_TAB   = 21'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 21'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 21'h0D;
  localparam logic [CHAR_W-1:0] CH_SP    = 21'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 21'h22;
  localparam logic [CHAR_W-1:0] CH_LP    = 21'h28;
  localparam logic [CHAR_W-1:0] CH_RP    = 21'h29;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 21'h3B;
  localparam logic [CHAR_W-1:0] CH_BSL   = 21'h5C;
  localparam logic [CHAR_W-1:0] CH_N     = 21'h6E;
  localparam logic [CHAR_W-1:0] CH_R     = 21'h72;
  localparam logic [CHAR_W-1:0] CH_T     = 21'h74;

  typedef enum logic [3:0] {
    MODE_BETWEEN = 4'b0001,
    MODE_COMMENT = 4'b0010,
    MODE_BARE    = 4'b0100,
    MODE_QUOTED  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]       event_kind;
    logic [NODE_W-1:0]       node;
    logic signed [PAR_W-1:0] parent;
    logic [START_W-1:0]      start_pos;
    logic [END_W-1:0]        end_pos;
    logic [CHAR_W-1:0]       value;
    logic                    quoted;
    logic                    is_head;
    logic                    ok;
    logic [CNT_W-1:0]        node_count;
    logic                    last;
  } res_t;

  // Stack entry: node index and its head-still-empty flag
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              he;
  } stk_t;

  // Up to two results per request
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } core_push_t;

endpackage

// ===== src/sst_stream_if.sv =====
interface sst_in_if import sst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [CHAR_W-1:0] character;

  modport source (output valid, output func, output character, input ready);
  modport sink   (input valid, input func, input character, output ready);
endinterface

interface sst_out_if import sst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       event_kind;
  logic [NODE_W-1:0]       node;
  logic signed [PAR_W-1:0] parent;
  logic [START_W-1:0]      start_pos;
  logic [END_W-1:0]        end_pos;
  logic [CHAR_W-1:0]       value;
  logic                    quoted;
  logic                    is_head;
  logic                    ok;
  logic [CNT_W-1:0]        node_count;
  logic                    last;

  modport source (
    output valid, output event_kind, output node, output parent, output start_pos,
    output end_pos, output value, output quoted, output is_head, output ok,
    output node_count, output last, input ready
  );
  modport sink (
    input valid, input event_kind, input node, input parent, input start_pos,
    input end_pos, input value, input quoted, input is_head, input ok,
    input node_count, input last, output ready
  );
endinterface

// ===== src/sst_ram.sv =====
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== src/sst_core.sv =====
module sst_core
  import sst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic              func,
  input  logic [CHAR_W-1:0] character,
  output core_push_t        push
);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  mode_t              mode_r, mode_nxt;
  logic               esc_r, esc_nxt;
  logic [START_W-1:0] astart_r, astart_nxt;
  logic               anon_r, anon_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [NODE_W-1:0]  top_node_r, top_node_nxt;
  logic               top_he_r, top_he_nxt;
  logic [NODES_W-1:0] nodes_r, nodes_nxt;
  logic               err_r, err_nxt;
  logic               byp_r, byp_nxt;
  stk_t               byp_wd_r;

  logic [$bits(stk_t)-1:0] ram_rdata;
  stk_t               below;
  stk_t               st_wdata;
  logic               st_we;
  logic [DEPTH_W-1:0] dm1, rd_depth, rd_tmp;

  res_t       r0, r1, ae, ac, bres, fin;
  logic [1:0] n;
  logic       bvalid, go_between, blank, delim;
  logic [CHAR_W-1:0] decoded;

  // Entry just below the top: RAM read of depth-2, or the entry pushed last cycle
  assign below = byp_r ? byp_wd_r : stk_t'(ram_rdata);

  assign dm1      = depth_r - DEPTH_W'(1);
  assign rd_depth = acc ? depth_nxt : depth_r;
  assign rd_tmp   = rd_depth - DEPTH_W'(2);

  sst_ram #(
    .WIDTH ($bits(stk_t)),
    .DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (acc && st_we),
    .waddr (dm1[ADDR_W-1:0]),
    .wdata (st_wdata),
    .raddr (rd_tmp[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign byp_nxt = acc && st_we;

  always_comb begin
    blank = character inside {CH_SP, CH_TAB, CH_CR, CH_LF};
    delim = blank || character == CH_LP || character == CH_RP || character == CH_SEMI;

    case (character)
      CH_N:    decoded = CH_LF;
      CH_R:    decoded = CH_CR;
      CH_T:    decoded = CH_TAB;
      default: decoded = character;
    endcase

    ae            = '0;
    ae.event_kind = EV_ATOM_END;
    ae.node       = top_node_r;
    ae.start_pos  = astart_r;
    ae.end_pos    = pos_r;
    ae.is_head    = top_he_r;
    ae.node_count = nodes_r;

    ac            = '0;
    ac.event_kind = EV_ATOM_CHAR;
    ac.node       = top_node_r;
    ac.start_pos  = astart_r;
    ac.value      = character;
    ac.is_head    = top_he_r;
    ac.node_count = nodes_r;

    fin            = '0;
    fin.event_kind = EV_FINISH;
    fin.node_count = nodes_r;
    fin.ok = !err_r && depth_r == '0 && nodes_r != '0 && mode_r != MODE_QUOTED;

    pos_nxt      = pos_r;
    mode_nxt     = mode_r;
    esc_nxt      = esc_r;
    astart_nxt   = astart_r;
    anon_nxt     = anon_r;
    depth_nxt    = depth_r;
    top_node_nxt = top_node_r;
    top_he_nxt   = top_he_r;
    nodes_nxt    = nodes_r;
    err_nxt      = err_r;
    st_we        = 1'b0;
    st_wdata     = '{node: top_node_r, he: top_he_r};
    r0           = '0;
    r1           = '0;
    n            = 2'd0;
    bres         = '0;
    bvalid       = 1'b0;
    go_between   = 1'b0;

    if (func) begin
      if (!err_r && mode_r == MODE_BARE) begin
        r0 = ae;
        r1 = fin;
        n  = 2'd2;
      end else begin
        r0 = fin;
        n  = 2'd1;
      end
      pos_nxt    = '0;
      mode_nxt   = MODE_BETWEEN;
      esc_nxt    = 1'b0;
      astart_nxt = '0;
      anon_nxt   = 1'b0;
      depth_nxt  = '0;
      nodes_nxt  = '0;
      err_nxt    = 1'b0;
    end else if (!err_r) begin
      if (pos_r >= POS_W'(MAX_CHARS)) begin
        err_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        case (mode_r)
          MODE_COMMENT: begin
            if (character == CH_LF) mode_nxt = MODE_BETWEEN;
          end
          MODE_BARE: begin
            if (delim) begin
              r0 = ae;
              n  = 2'd1;
              if (top_he_r && anon_r) top_he_nxt = 1'b0;
              mode_nxt   = MODE_BETWEEN;
              go_between = 1'b1;
            end else begin
              r0       = ac;
              n        = 2'd1;
              anon_nxt = 1'b1;
            end
          end
          MODE_QUOTED: begin
            if (esc_r) begin
              esc_nxt   = 1'b0;
              r0        = ac;
              r0.value  = decoded;
              r0.quoted = 1'b1;
              n         = 2'd1;
              anon_nxt  = 1'b1;
            end else if (character == CH_BSL) begin
              esc_nxt = 1'b1;
            end else if (character == CH_QUOTE) begin
              r0         = ae;
              r0.end_pos = pos_r + POS_W'(1);
              r0.quoted  = 1'b1;
              n          = 2'd1;
              if (top_he_r && anon_r) top_he_nxt = 1'b0;
              mode_nxt   = MODE_BETWEEN;
            end else begin
              r0        = ac;
              r0.quoted = 1'b1;
              n         = 2'd1;
              anon_nxt  = 1'b1;
            end
          end
          default: go_between = 1'b1;
        endcase

        if (go_between && !blank) begin
          if (character == CH_SEMI) begin
            mode_nxt = MODE_COMMENT;
          end else if (character == CH_LP) begin
            if (depth_r >= DEPTH_W'(MAX_DEPTH) || nodes_r >= NODES_W'(MAX_NODES)) begin
              err_nxt = 1'b1;
            end else begin
              bres.event_kind = EV_OPEN;
              bres.node       = nodes_r[NODE_W-1:0];
              bres.parent     = (depth_r != '0) ? $signed({1'b0, top_node_r}) : PARENT_ROOT;
              bres.start_pos  = pos_r[START_W-1:0];
              bres.node_count = CNT_W'(nodes_r + NODES_W'(1));
              bvalid          = 1'b1;
              // old top moves into the RAM with its possibly updated head flag
              st_wdata     = '{node: top_node_r, he: top_he_nxt};
              st_we        = depth_r != '0;
              top_node_nxt = nodes_r[NODE_W-1:0];
              top_he_nxt   = 1'b1;
              depth_nxt    = depth_r + DEPTH_W'(1);
              nodes_nxt    = nodes_r + NODES_W'(1);
            end
          end else if (character == CH_RP) begin
            if (depth_r == '0) begin
              err_nxt = 1'b1;
            end else begin
              bres.event_kind = EV_CLOSE;
              bres.node       = top_node_r;
              bres.end_pos    = pos_r + POS_W'(1);
              bres.node_count = nodes_r;
              bvalid          = 1'b1;
              top_node_nxt    = below.node;
              top_he_nxt      = below.he;
              depth_nxt       = dm1;
            end
          end else if (depth_r == '0) begin
            err_nxt = 1'b1;
          end else begin
            astart_nxt = pos_r[START_W-1:0];
            esc_nxt    = 1'b0;
            if (character == CH_QUOTE) begin
              mode_nxt = MODE_QUOTED;
              anon_nxt = 1'b0;
            end else begin
              mode_nxt       = MODE_BARE;
              bres           = ac;
              bres.start_pos = pos_r[START_W-1:0];
              bvalid         = 1'b1;
              anon_nxt       = 1'b1;
            end
          end
        end

        if (bvalid) begin
          if (n == 2'd0) begin
            r0 = bres;
            n  = 2'd1;
          end else begin
            r1 = bres;
            n  = 2'd2;
          end
        end
      end
    end

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end else if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  always_comb begin
    push.n  = acc ? n : 2'd0;
    push.r0 = r0;
    push.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      mode_r   <= MODE_BETWEEN;
      esc_r    <= 1'b0;
      astart_r <= '0;
      anon_r   <= 1'b0;
      depth_r  <= '0;
      nodes_r  <= '0;
      err_r    <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      byp_r <= byp_nxt;
      if (acc) begin
        pos_r    <= pos_nxt;
        mode_r   <= mode_nxt;
        esc_r    <= esc_nxt;
        astart_r <= astart_nxt;
        anon_r   <= anon_nxt;
        depth_r  <= depth_nxt;
        nodes_r  <= nodes_nxt;
        err_r    <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_wd_r <= st_wdata;
    if (acc) begin
      top_node_r <= top_node_nxt;
      top_he_r   <= top_he_nxt;
    end
  end

endmodule

// ===== src/sst_out_fifo.sv =====
module sst_out_fifo
  import sst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  core_push_t push,
  output logic       room,
  output logic       head_valid,
  output res_t       head,
  input  logic       pop
);

  res_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp1;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_pop;

  assign do_pop     = pop && head_valid;
  assign head_valid = cnt_r != '0;
  assign head       = mem_r[rp_r];
  // a request can bring two results
  assign room       = cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2);

  assign wp1     = wp_r + FIFO_PTR_W'(1);
  assign wp_nxt  = wp_r + FIFO_PTR_W'(push.n);
  assign rp_nxt  = rp_r + FIFO_PTR_W'(do_pop);
  assign cnt_nxt = cnt_r + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wp1] <= push.r1;
    end
  end

endmodule

// ===== src/sexpr_stream_tokenizer.sv =====
// Channel   Dir  Payload                                             Accept
// in_chan   in   func, character                                     valid & ready
// out_chan  out  event_kind, node, parent, start_pos, end_pos,       valid & ready
//                value, quoted, is_head, ok, node_count, last
//
// One request per cycle while in_chan.ready is high; each is parsed in
// the cycle it is accepted and its results (up to two) land in a 4-entry
// result queue, one leaving per cycle while out_chan.ready is high.
// in_chan.ready drops while the queue has fewer than two free entries.
// Open-node stack is a 64-entry RAM with the top held in registers.
// Reset is synchronous; the stack RAM is not cleared.
module sexpr_stream_tokenizer
  import sst_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  sst_in_if.sink    in_chan,
  sst_out_if.source out_chan
);

  logic       acc;
  logic       room;
  core_push_t push;
  res_t       head;

  assign in_chan.ready = room;
  assign acc           = in_chan.valid && room;

  sst_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .func      (in_chan.func),
    .character (in_chan.character),
    .push      (push)
  );

  sst_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (out_chan.valid),
    .head       (head),
    .pop        (out_chan.ready)
  );

  assign out_chan.event_kind = head.event_kind;
  assign out_chan.node       = head.node;
  assign out_chan.parent     = head.parent;
  assign out_chan.start_pos  = head.start_pos;
  assign out_chan.end_pos    = head.end_pos;
  assign out_chan.value      = head.value;
  assign out_chan.quoted     = head.quoted;
  assign out_chan.is_head    = head.is_head;
  assign out_chan.ok         = head.ok;
  assign out_chan.node_count = head.node_count;
  assign out_chan.last       = head.last;

endmodule

// ===== tb/sexpr_stream_tokenizer_test.sv =====
`timescale 1ns / 100ps

module sexpr_stream_tokenizer_test;
  import sst_pkg::*;

  localparam logic [CHAR_W-1:0] CH_LOWER_A = 21'h61;
  localparam logic [CHAR_W-1:0] CH_MAX     = 21'h1FFFFF;
  localparam int                RANDOM_ITEMS = 350;

  // Expected parse events, predicted per accepted request
  class sexpr_event_board;
    logic [END_W-1:0]   pos;
    mode_t              scan;
    bit                 esc;
    logic [START_W-1:0] atom_start;
    bit                 atom_nonempty;
    logic [DEPTH_W-1:0] depth;
    logic [NODE_W-1:0]  node_stack[MAX_DEPTH];
    bit                 head_open[MAX_DEPTH];
    logic [CNT_W-1:0]   opened;
    bit                 err;
    res_t               step_q[$];
    res_t               expected_q[$];
    int unsigned        fail_count;
    int unsigned        n_checked;
    int unsigned        n_texts;
    int unsigned        n_clean;

    function new();
      foreach (node_stack[i]) begin
        node_stack[i] = '0;
        head_open[i]  = 1'b0;
      end
      fail_count = 0;
      n_checked  = 0;
      n_texts    = 0;
      n_clean    = 0;
      clear_state();
    endfunction

    function void clear_state();
      pos           = '0;
      scan          = MODE_BETWEEN;
      esc           = 1'b0;
      atom_start    = '0;
      atom_nonempty = 1'b0;
      depth         = '0;
      opened        = '0;
      err           = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit is_blank(logic [CHAR_W-1:0] c);
      return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function int top();
      return (depth == 0) ? 0 : int'(depth) - 1;
    endfunction

    function void emit(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] nd,
                       logic signed [PAR_W-1:0] par, logic [START_W-1:0] sp,
                       logic [END_W-1:0] ep, logic [CHAR_W-1:0] val, bit q, bit h);
      res_t r;
      r.event_kind = kind;
      r.node       = nd;
      r.parent     = par;
      r.start_pos  = sp;
      r.end_pos    = ep;
      r.value      = val;
      r.quoted     = q;
      r.is_head    = h;
      r.ok         = 1'b0;
      r.node_count = opened;
      r.last       = 1'b0;
      step_q = {step_q, r};
    endfunction

    function void add_char(logic [CHAR_W-1:0] v, bit q);
      int t;
      t = top();
      emit(EV_ATOM_CHAR, node_stack[t], '0, atom_start, '0, v, q, head_open[t]);
      atom_nonempty = 1'b1;
    endfunction

    function void end_atom(logic [END_W-1:0] ep, bit q);
      int t;
      bit h;
      t = top();
      h = head_open[t];
      emit(EV_ATOM_END, node_stack[t], '0, atom_start, ep, '0, q, h);
      // an empty quoted head leaves the slot open
      if (h && atom_nonempty) head_open[t] = 1'b0;
      scan = MODE_BETWEEN;
    endfunction

    function void scan_between(logic [CHAR_W-1:0] c);
      logic signed [PAR_W-1:0] par;
      if (is_blank(c)) return;
      if (c == CH_SEMI) begin
        scan = MODE_COMMENT;
        return;
      end
      if (c == CH_LP) begin
        if (depth >= MAX_DEPTH || opened >= MAX_NODES) begin
          err = 1'b1;
          return;
        end
        par = (depth != 0) ? $signed({1'b0, node_stack[top()]}) : PARENT_ROOT;
        node_stack[depth] = opened[NODE_W-1:0];
        head_open[depth]  = 1'b1;
        depth++;
        opened++;
        emit(EV_OPEN, node_stack[depth - 1], par, pos[START_W-1:0], '0, '0, 1'b0, 1'b0);
        return;
      end
      if (c == CH_RP) begin
        if (depth == 0) begin
          err = 1'b1;
          return;
        end
        emit(EV_CLOSE, node_stack[top()], '0, '0, pos + 1'b1, '0, 1'b0, 1'b0);
        depth--;
        return;
      end
      if (depth == 0) begin
        err = 1'b1;
        return;
      end
      atom_start    = pos[START_W-1:0];
      esc           = 1'b0;
      atom_nonempty = 1'b0;
      if (c == CH_QUOTE) begin
        scan = MODE_QUOTED;
      end else begin
        scan = MODE_BARE;
        add_char(c, 1'b0);
      end
    endfunction

    function void scan_quoted(logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] v;
      if (esc) begin
        esc = 1'b0;
        case (c)
          CH_N:    v = CH_LF;
          CH_R:    v = CH_CR;
          CH_T:    v = CH_TAB;
          default: v = c;
        endcase
        add_char(v, 1'b1);
      end else if (c == CH_BSL) begin
        esc = 1'b1;
      end else if (c == CH_QUOTE) begin
        end_atom(pos + 1'b1, 1'b1);
      end else begin
        add_char(c, 1'b1);
      end
    endfunction

    function void note_request(logic f, logic [CHAR_W-1:0] c);
      res_t r;
      step_q.delete();
      if (f) begin
        if (!err && scan == MODE_BARE) end_atom(pos, 1'b0);
        emit(EV_FINISH, '0, '0, '0, '0, '0, 1'b0, 1'b0);
        r    = step_q[step_q.size() - 1];
        r.ok = !err && depth == 0 && opened != 0 && scan != MODE_QUOTED;
        n_texts++;
        if (r.ok) n_clean++;
        step_q[step_q.size() - 1] = r;
        clear_state();
      end else if (!err) begin
        if (pos >= MAX_CHARS) begin
          err = 1'b1;
        end else begin
          case (scan)
            MODE_COMMENT: if (c == CH_LF) scan = MODE_BETWEEN;
            MODE_BARE: begin
              if (is_blank(c) || c == CH_LP || c == CH_RP || c == CH_SEMI) begin
                end_atom(pos, 1'b0);
                scan_between(c);
              end else begin
                add_char(c, 1'b0);
              end
            end
            MODE_QUOTED: scan_quoted(c);
            default: scan_between(c);
          endcase
          pos++;
        end
      end
      if (step_q.size() != 0) begin
        r      = step_q[step_q.size() - 1];
        r.last = 1'b1;
        step_q[step_q.size() - 1] = r;
        expected_q = {expected_q, step_q};
      end
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (want === got) return 1'b1;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      return 1'b0;
    endfunction

    function void check_event(res_t got);
      res_t want;
      bit   good;
      if (expected_q.size() == 0) begin
        $error("event with nothing pending: kind %0d node %0d", got.event_kind, got.node);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      good = 1'b1;
      good &= field_ok("event_kind", 32'(want.event_kind), 32'(got.event_kind));
      good &= field_ok("node", 32'(want.node), 32'(got.node));
      good &= field_ok("parent", 32'(want.parent), 32'(got.parent));
      good &= field_ok("start_pos", 32'(want.start_pos), 32'(got.start_pos));
      good &= field_ok("end_pos", 32'(want.end_pos), 32'(got.end_pos));
      good &= field_ok("value", 32'(want.value), 32'(got.value));
      good &= field_ok("quoted", 32'(want.quoted), 32'(got.quoted));
      good &= field_ok("is_head", 32'(want.is_head), 32'(got.is_head));
      good &= field_ok("ok", 32'(want.ok), 32'(got.ok));
      good &= field_ok("node_count", 32'(want.node_count), 32'(got.node_count));
      good &= field_ok("last", 32'(want.last), 32'(got.last));
      if (!good) fail_count++;
      n_checked++;
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sst_in_if  req_if ();
  sst_out_if evt_if ();

  sexpr_stream_tokenizer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (evt_if)
  );

  sexpr_event_board board;
  logic [CHAR_W-1:0] text_q[$];
  int burst_left     = 0;
  int n_sent         = 0;
  int rx_hold_cycles = 0;
  bit tx_steady      = 1'b0;
  bit rx_steady      = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    res_t got;
    if (rst_n) begin
      if (evt_if.valid && evt_if.ready) begin
        got.event_kind = evt_if.event_kind;
        got.node       = evt_if.node;
        got.parent     = evt_if.parent;
        got.start_pos  = evt_if.start_pos;
        got.end_pos    = evt_if.end_pos;
        got.value      = evt_if.value;
        got.quoted     = evt_if.quoted;
        got.is_head    = evt_if.is_head;
        got.ok         = evt_if.ok;
        got.node_count = evt_if.node_count;
        got.last       = evt_if.last;
        board.check_event(got);
      end
      if (req_if.valid && req_if.ready) board.note_request(req_if.func, req_if.character);
    end
  end

  // Receiver: stall density changes per span; a requested hold-off overrides it
  initial begin : rx_pacer
    int span;
    int stall_pct;
    span      = 0;
    stall_pct = 0;
    evt_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        evt_if.ready <= 1'b0;
        rx_hold_cycles--;
      end else if (rx_steady || !rst_n) begin
        evt_if.ready <= 1'b1;
      end else begin
        if (span == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
          span = $urandom_range(8, 60);
        end
        span--;
        evt_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Entered and left at a falling edge
  task automatic send_req(input logic f, input logic [CHAR_W-1:0] c);
    int gap;
    if (!tx_steady && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    req_if.valid     <= 1'b1;
    req_if.func      <= f;
    req_if.character <= c;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    n_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_req(1'b0, {13'b0, s[i]});
  endtask

  task automatic end_text();
    send_req(1'b1, CHAR_W'($urandom_range(0, CH_MAX)));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  function automatic void add_ch(input logic [CHAR_W-1:0] c);
    text_q = {text_q, c};
  endfunction

  function automatic logic [CHAR_W-1:0] pick_letter();
    return CH_LOWER_A + CHAR_W'($urandom_range(0, 25));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return CH_SP;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic void build_noise();
    int len;
    text_q.delete();
    len = $urandom_range(5, 20);
    repeat (len) begin
      case ($urandom_range(0, 8))
        0:       add_ch(CH_LP);
        1:       add_ch(CH_RP);
        2:       add_ch(CH_QUOTE);
        3:       add_ch(CH_BSL);
        4:       add_ch(CH_SEMI);
        5:       add_ch(CH_SP);
        6:       add_ch(CH_LF);
        7:       add_ch(pick_letter());
        default: add_ch(CHAR_W'($urandom_range(0, CH_MAX)));
      endcase
    end
  endfunction

  // Mostly balanced text with random atoms, strings, escapes and comments
  function automatic void build_text();
    int lvl;
    int len;
    text_q.delete();
    add_ch(CH_LP);
    lvl = 1;
    repeat ($urandom_range(3, 14)) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          if (lvl < 5) begin
            add_ch(CH_LP);
            lvl++;
          end else begin
            add_ch(CH_SP);
          end
        end
        2: begin
          if (lvl > 1) begin
            add_ch(CH_RP);
            lvl--;
          end else begin
            add_ch(pick_blank());
          end
        end
        3, 4: begin
          add_ch(pick_letter());
          len = $urandom_range(0, 3);
          repeat (len) begin
            case ($urandom_range(0, 5))
              0:       add_ch(CHAR_W'($urandom_range(0, CH_MAX)));
              1:       add_ch(CH_QUOTE);
              2:       add_ch(CH_BSL);
              default: add_ch(pick_letter());
            endcase
          end
          if ($urandom_range(0, 2) != 0) add_ch(pick_blank());
        end
        5, 6: begin
          add_ch(CH_QUOTE);
          len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4);
          repeat (len) begin
            if ($urandom_range(0, 3) == 0) begin
              add_ch(CH_BSL);
              case ($urandom_range(0, 6))
                0:       add_ch(CH_N);
                1:       add_ch(CH_R);
                2:       add_ch(CH_T);
                3:       add_ch(CH_BSL);
                4:       add_ch(CH_QUOTE);
                5:       add_ch(CHAR_W'($urandom_range(0, CH_MAX)));
                default: add_ch(pick_letter());
              endcase
            end else if ($urandom_range(0, 2) == 0) begin
              add_ch(CHAR_W'($urandom_range(21'h80, CH_MAX)));
            end else begin
              add_ch(pick_letter());
            end
          end
          add_ch(CH_QUOTE);
        end
        7: begin
          add_ch(CH_SEMI);
          repeat ($urandom_range(0, 3)) add_ch(pick_letter());
          add_ch(CH_LF);
        end
        default: add_ch(pick_blank());
      endcase
    end
    // now and then leave the text unbalanced
    if ($urandom_range(0, 9) != 0) repeat (lvl) add_ch(CH_RP);
  endfunction

  initial begin : stimulus
    int target;
    int text_no;
    board = new();
    req_if.valid     = 1'b0;
    req_if.func      = 1'b0;
    req_if.character = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // field extremes: NUL, all-ones and beyond-Unicode atom characters
    send_req(1'b0, CH_LP);
    send_req(1'b0, CH_MAX);
    send_req(1'b0, 21'h000000);
    send_req(1'b0, 21'h110000);
    send_req(1'b0, CH_RP);
    end_text();
    // empty quoted head, escapes, comment
    send_text("(\"\"x \"\\n\\q\";\n)");
    end_text();
    send_text(")");
    end_text();
    send_text("a");
    end_text();
    send_text("(b");
    end_text();
    send_text("(\"u");
    end_text();
    end_text();

    // depth overflow, run at full rate
    wait_drained();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (MAX_DEPTH + 1) send_req(1'b0, CH_LP);
    send_req(1'b0, CH_RP);
    end_text();
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    target  = n_sent + RANDOM_ITEMS;
    text_no = 0;
    while (n_sent < target) begin
      if (text_no == 1) rx_hold_cycles = 150;
      if (text_no == 4) wait_drained();
      if ($urandom_range(0, 6) == 0) build_noise();
      else build_text();
      foreach (text_q[i]) send_req(1'b0, text_q[i]);
      end_text();
      text_no++;
    end

    wait_drained();
    repeat (16) @(negedge clk);
    $display("Checked %0d events from %0d requests over %0d texts, %0d of them parsed clean.",
             board.n_checked, n_sent, board.n_texts, board.n_clean);
    $display("Covered escapes, comments, empty heads, sticky errors, depth overflow, full rate.");
    if (board.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d events still pending.", board.pending());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/sst_pkg.sv
src/sst_stream_if.sv
src/sst_ram.sv
src/sst_core.sv
src/sst_out_fifo.sv
src/sexpr_stream_tokenizer.sv
tb/sexpr_stream_tokenizer_test.sv
